[rtl/core/cdrom_host_register_interface_macros.svh]
// Assertion helpers for the host register interface checker.
`ifndef CDROM_HOST_REGISTER_INTERFACE_MACROS_SVH
`define CDROM_HOST_REGISTER_INTERFACE_MACROS_SVH

// Checked only out of reset.
`define CDRHI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CDRHI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/cdrhi_pkg.sv]
package cdrhi_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] PORT_INDEX = 2'd0;
    localparam logic [1:0] PORT_CMD   = 2'd1;
    localparam logic [1:0] PORT_PARAM = 2'd2;
    localparam logic [1:0] PORT_REQ   = 2'd3;

    localparam logic [1:0] BANK_0 = 2'd0;
    localparam logic [1:0] BANK_1 = 2'd1;
    localparam logic [1:0] BANK_2 = 2'd2;
    localparam logic [1:0] BANK_3 = 2'd3;

    localparam logic [7:0] CMD_GETSTAT = 8'h01;
    localparam logic [7:0] CMD_TEST    = 8'h19;
    localparam logic [7:0] SUB_GETVER  = 8'h20;

    localparam logic [7:0] RESP_STATUS_BYTE = 8'h00;
    localparam logic [7:0] VER_BYTE_FIRST   = 8'd90;
    localparam logic [7:0] VER_BYTE_REST    = 8'd1;

    localparam int REQ_SMEN_BIT   = 5;
    localparam int ACK_PCLEAR_BIT = 6;
    localparam int INT10_BIT      = 4;

    localparam logic [2:0] INT3_BITS     = 3'b011;
    localparam logic [2:0] READ_HIGH_SET = 3'b111;

    localparam logic REC_STATUS  = 1'b0;
    localparam logic REC_VERSION = 1'b1;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push_status;
        logic push_version;
    } resp_ctl_t;

endpackage

[rtl/core/cdrhi_fifo.sv]
module cdrhi_fifo
    import cdrhi_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [DATA_W-1:0]            push_data,
    input  logic                         pop,
    input  logic                         clear,
    output logic [DATA_W-1:0]            head,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] head_reg;
    logic [PW-1:0]     rd_reg, rd_next;
    logic [PW-1:0]     wr_reg, wr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign do_push = push && (count_reg != CW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb
    begin
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        count_next = count_reg;
        if (clear)
        begin
            rd_next    = '0;
            wr_next    = '0;
            count_next = '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_next = ptr_inc(wr_reg);
            end
            if (do_pop)
            begin
                rd_next = ptr_inc(rd_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_next = count_reg + 1'b1;
                2'b01:   count_next = count_reg - 1'b1;
                default: count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg    <= '0;
            wr_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            count_reg <= count_next;
        end
    end

    // head is prefetched from the next read address, with write bypass
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
        if (do_push && (wr_reg == rd_next))
        begin
            head_reg <= push_data;
        end
        else
        begin
            head_reg <= mem[rd_next];
        end
    end

    assign head  = head_reg;
    assign count = count_reg;

endmodule

[rtl/core/cdrhi_resp.sv]
module cdrhi_resp
    import cdrhi_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  resp_ctl_t                    ctl,
    output logic [7:0]                   head_byte,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int CW = $clog2(DEPTH + 1);

    // one record per pushed response: {kind, length - 1}
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    off_reg, off_next;
    logic [CW-1:0] room;
    logic [1:0]    ver_len_m1;
    logic [CW-1:0] ver_len;
    logic          rec_push, rec_pop, byte_pop;
    logic [2:0]    rec_data;
    logic [2:0]    rec_head;
    logic [CW-1:0] rec_count;

    assign room       = CW'(DEPTH) - count_reg;
    assign ver_len_m1 = (room >= CW'(4)) ? 2'd3 : room[1:0] - 2'd1;
    assign ver_len    = CW'(ver_len_m1) + 1'b1;
    assign byte_pop   = ctl.pop && (count_reg != '0);
    assign rec_pop    = byte_pop && (off_reg == rec_head[1:0]);

    always_comb
    begin
        rec_push   = 1'b0;
        rec_data   = {REC_STATUS, 2'd0};
        count_next = count_reg;
        off_next   = off_reg;
        if (ctl.clear)
        begin
            count_next = '0;
            off_next   = '0;
        end
        else if (ctl.push_status && (room != '0))
        begin
            rec_push   = 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.push_version && (room != '0))
        begin
            rec_push   = 1'b1;
            rec_data   = {REC_VERSION, ver_len_m1};
            count_next = count_reg + ver_len;
        end
        else if (byte_pop)
        begin
            count_next = count_reg - 1'b1;
            off_next   = rec_pop ? 2'd0 : off_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            off_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            off_reg   <= off_next;
        end
    end

    cdrhi_fifo #(
        .DEPTH  (DEPTH),
        .DATA_W (3)
    ) u_rec_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_data),
        .pop       (rec_pop && !ctl.clear),
        .clear     (ctl.clear),
        .head      (rec_head),
        .count     (rec_count)
    );

    always_comb
    begin
        if (rec_count == '0 || rec_head[2] == REC_STATUS)
        begin
            head_byte = RESP_STATUS_BYTE;
        end
        else if (off_reg == 2'd0)
        begin
            head_byte = VER_BYTE_FIRST;
        end
        else
        begin
            head_byte = VER_BYTE_REST;
        end
    end

    assign count = count_reg;

endmodule

[rtl/core/cdrom_host_register_interface.sv]
// Host register interface of a CD drive controller, one byte bus access per transfer.
// Input channel s_*: s_tuser is the access kind (0 read, 1 write); s_tdata carries the
// port offset and the write byte. Output channel m_*: one result per access, carrying
// the read byte, an interrupt pulse and an error flag.
// Each access is decoded against the current bank index and applied to the FIFO heads
// and the small registers; the result lands in the output register on the edge that
// accepts the access, so throughput is 1 access per cycle while m_tready does not stall the output.
// The FIFO heads are prefetched from their memories into registers, so no access waits
// on a memory read.
// Reset clears the bank index, FIFO pointers and counts, interrupt enable and flags and
// the request register; volume bytes return to 0x80. FIFO storage is not cleared.
// When m_tready is low with a result pending, s_tready drops and no state changes until
// the result is taken; a result waiting in the output register does not block a new
// access in the cycle it is taken.
module cdrom_host_register_interface
    import cdrhi_pkg::*;
#(
    parameter int FIFO_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] port, [9:2] write_byte, [15:10] zero
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_byte, [8] irq_pulse, [9] error, rest zero
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic        acc;
    logic [1:0]  in_port;
    logic [7:0]  in_byte;

    logic [1:0]  bank_reg, bank_next;
    logic [4:0]  en_reg, en_next;
    logic [4:0]  flags_reg, flags_next;
    logic [7:0]  req_reg, req_next;
    logic [7:0]  vol_reg [4];
    logic [7:0]  vol_next [4];

    logic        m_valid_reg;
    logic [7:0]  rd_byte_reg, rd_byte_next;
    logic        irq_reg, irq_next;
    logic        err_reg, err_next;

    logic          pf_push, pf_pop, pf_clear;
    logic [7:0]    pf_head;
    logic [CW-1:0] pf_count;
    resp_ctl_t     rctl;
    logic [7:0]    resp_head;
    logic [CW-1:0] resp_count;

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;
    assign in_port  = s_tdata[1:0];
    assign in_byte  = s_tdata[9:2];

    always_comb
    begin
        logic [4:0] f;
        logic [7:0] sub;
        logic       int3;

        f            = flags_reg;
        sub          = '0;
        int3         = 1'b0;
        bank_next    = bank_reg;
        en_next      = en_reg;
        flags_next   = flags_reg;
        req_next     = req_reg;
        vol_next     = vol_reg;
        rd_byte_next = '0;
        irq_next     = 1'b0;
        err_next     = 1'b0;
        pf_push      = 1'b0;
        pf_pop       = 1'b0;
        pf_clear     = 1'b0;
        rctl         = '0;

        if (acc && s_tuser == OP_WRITE)
        begin
            case (in_port)
                PORT_INDEX:
                begin
                    bank_next = in_byte[1:0];
                end
                PORT_CMD:
                begin
                    if (bank_reg == BANK_0)
                    begin
                        if (req_reg[REQ_SMEN_BIT])
                        begin
                            irq_next     = !f[INT10_BIT] && en_reg[INT10_BIT];
                            f[INT10_BIT] = 1'b1;
                        end
                        case (in_byte)
                            CMD_GETSTAT:
                            begin
                                rctl.push_status = 1'b1;
                                int3             = 1'b1;
                            end
                            CMD_TEST:
                            begin
                                pf_pop = (pf_count != '0);
                                sub    = (pf_count != '0) ? pf_head : 8'h00;
                                if (sub == SUB_GETVER)
                                begin
                                    rctl.push_version = 1'b1;
                                    int3              = 1'b1;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                end
                            end
                            default:
                            begin
                                err_next = 1'b1;
                            end
                        endcase
                        if (int3)
                        begin
                            if (f[2:0] == 3'b000
                                && (en_reg[2:0] & (f[2:0] | INT3_BITS)) != 3'b000)
                            begin
                                irq_next = 1'b1;
                            end
                            f[2:0] = f[2:0] | INT3_BITS;
                        end
                        flags_next = f;
                    end
                    else if (bank_reg == BANK_3)
                    begin
                        vol_next[3] = in_byte;
                    end
                end
                PORT_PARAM:
                begin
                    case (bank_reg)
                        BANK_0:  pf_push     = 1'b1;
                        BANK_1:  en_next     = in_byte[4:0];
                        BANK_2:  vol_next[0] = in_byte;
                        default: vol_next[2] = in_byte;
                    endcase
                end
                default:
                begin
                    case (bank_reg)
                        BANK_0:
                        begin
                            req_next = in_byte;
                        end
                        BANK_1:
                        begin
                            pf_clear = in_byte[ACK_PCLEAR_BIT];
                            f        = flags_reg & ~in_byte[4:0];
                            if (flags_reg[2:0] != 3'b000 && f[2:0] == 3'b000)
                            begin
                                rctl.clear = 1'b1;
                            end
                            flags_next = f;
                        end
                        BANK_2:
                        begin
                            vol_next[1] = in_byte;
                        end
                        default:
                        begin
                            vol_next = vol_reg;
                        end
                    endcase
                end
            endcase
        end
        else if (acc)
        begin
            case (in_port)
                PORT_INDEX:
                begin
                    rd_byte_next = {2'b00, resp_count != '0,
                                    pf_count != CW'(FIFO_DEPTH), pf_count == '0,
                                    1'b0, bank_reg};
                end
                PORT_CMD:
                begin
                    rctl.pop     = (resp_count != '0);
                    rd_byte_next = (resp_count != '0) ? resp_head : 8'h00;
                end
                PORT_PARAM:
                begin
                    rd_byte_next = 8'h00;
                end
                default:
                begin
                    rd_byte_next = {READ_HIGH_SET, bank_reg[0] ? flags_reg : en_reg};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= BANK_0;
            en_reg      <= '0;
            flags_reg   <= '0;
            req_reg     <= '0;
            vol_reg     <= '{default: 8'h80};
            m_valid_reg <= 1'b0;
        end
        else
        begin
            bank_reg  <= bank_next;
            en_reg    <= en_next;
            flags_reg <= flags_next;
            req_reg   <= req_next;
            vol_reg   <= vol_next;
            if (acc)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_byte_reg <= rd_byte_next;
            irq_reg     <= irq_next;
            err_reg     <= err_next;
        end
    end

    cdrhi_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .DATA_W (8)
    ) u_param_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pf_push),
        .push_data (in_byte),
        .pop       (pf_pop),
        .clear     (pf_clear),
        .head      (pf_head),
        .count     (pf_count)
    );

    cdrhi_resp #(
        .DEPTH (FIFO_DEPTH)
    ) u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (rctl),
        .head_byte (resp_head),
        .count     (resp_count)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000, err_reg, irq_reg, rd_byte_reg};

endmodule

[rtl/core/cdrhi_checker.sv]
`include "cdrom_host_register_interface_macros.svh"

module cdrhi_checker
    import cdrhi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `CDRHI_ASSERT_ALWAYS(a_idle_in_reset, (!rst_n |-> !m_tvalid), "result valid in reset")

    `CDRHI_ASSERT(a_read_no_flags, (s_tvalid && s_tready && s_tuser == OP_READ |=> m_tvalid && m_tdata[9:8] == 2'b00), "read reported irq or error")

    `CDRHI_ASSERT(a_write_zero_data, (s_tvalid && s_tready && s_tuser == OP_WRITE |=> m_tvalid && m_tdata[7:0] == 8'h00), "write returned data")

    `CDRHI_ASSERT(a_status_fixed_bits, (s_tvalid && s_tready && s_tuser == OP_READ && s_tdata[1:0] == PORT_INDEX |=> m_tdata[7:6] == 2'b00 && m_tdata[2] == 1'b0), "status fixed bits set")

    `CDRHI_ASSERT(a_irq_read_high, (s_tvalid && s_tready && s_tuser == OP_READ && s_tdata[1:0] == PORT_REQ |=> m_tdata[7:5] == READ_HIGH_SET), "interrupt read high bits clear")

endmodule

bind cdrom_host_register_interface cdrhi_checker u_checker (.*);
